>>> hdl/ppt_pkg.sv
// Shared types and constants for the point-in-polygon test block.
package ppt_pkg;

  // Request command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Fixed field widths
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  // Query sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } ppt_state_t;

  // Control from the sequencer to the edge unit
  typedef struct packed {
    logic clear;     // new query: reset the inside flag
    logic rd_vld;    // vertex read data valid this cycle
    logic rd_first;  // this read opens the walk, no edge yet
  } ppt_edge_ctl_t;

endpackage

>>> hdl/ppt_edge_unit.sv
// Pipelined edge evaluator: crossing test for one edge per cycle, even-odd flag.
module ppt_edge_unit import ppt_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppt_edge_ctl_t                 ctl,
  input  logic signed [COORD_WIDTH-1:0] rd_x,
  input  logic signed [COORD_WIDTH-1:0] rd_y,
  input  logic signed [COORD_WIDTH-1:0] qx,
  input  logic signed [COORD_WIDTH-1:0] qy,
  output logic                          parity,
  output logic                          pipe_busy
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // Previous vertex: start point of the current edge
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r;

  // Stage 1: differences
  logic                 s1_vld_r;
  logic                 s1_straddle_r;
  logic signed [DW-1:0] s1_a_r, s1_dy_r, s1_rx_r, s1_ry_r;

  // Stage 2: products
  logic                 s2_vld_r;
  logic                 s2_straddle_r;
  logic                 s2_dy_pos_r;
  logic signed [PW-1:0] s2_p1_r, s2_p2_r;

  logic                 inside_r;

  logic                 straddle_c;
  logic signed [DW-1:0] dy_c, a_c, rx_c, ry_c;
  logic                 right_c;

  // Edge from prev to current read vertex
  assign straddle_c = (prev_y_r > qy) != (rd_y > qy);
  assign dy_c = DW'(rd_y) - DW'(prev_y_r);
  assign a_c  = DW'(qx) - DW'(prev_x_r);
  assign rx_c = DW'(rd_x) - DW'(prev_x_r);
  assign ry_c = DW'(qy) - DW'(prev_y_r);

  // Exact crossing test, direction set by sign of dy
  assign right_c = s2_dy_pos_r ? (s2_p1_r < s2_p2_r) : (s2_p2_r < s2_p1_r);

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.rd_vld & ~ctl.rd_first;
      s2_vld_r <= s1_vld_r;
      if (ctl.clear) begin
        inside_r <= 1'b0;
      end else if (s2_vld_r && s2_straddle_r && right_c) begin
        inside_r <= ~inside_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.rd_vld) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    s1_straddle_r <= straddle_c;
    s1_a_r        <= a_c;
    s1_dy_r       <= dy_c;
    s1_rx_r       <= rx_c;
    s1_ry_r       <= ry_c;
    s2_straddle_r <= s1_straddle_r;
    s2_dy_pos_r   <= ~s1_dy_r[DW-1];
    s2_p1_r       <= s1_a_r * s1_dy_r;
    s2_p2_r       <= s1_rx_r * s1_ry_r;
  end

  assign parity    = inside_r;
  assign pipe_busy = s1_vld_r | s2_vld_r;

endmodule

>>> hdl/point_in_polygon_test.sv
// Point-in-polygon test: vertex store, query sequencer and result strobe.
//
// Requests enter on start/in_* and are taken when start is high and busy is
// low. A store request (in_cmd = store) writes one vertex into the store in
// that cycle and leaves busy low, so stores may follow back to back. A
// query request walks vertex_count edges (capped at MAX_VERTICES, wrapping
// from the last vertex to the first) and returns inside/outside by the
// even-odd rule on out_inside_res with a one-cycle out_strobe.
// The vertex store has one registered read port; it is read once per cycle
// (n vertices, then vertex 0 again), so the edge pipeline sees one edge per
// cycle. For n vertices busy falls in the cycle in which out_strobe rises; with
// n = 0 the answer is outside. cfg_we/cfg_wdata set vertex_count; write it
// while idle. Reset clears the sequencer and vertex_count; store contents are
// undefined until written. The receiver cannot stall: each result is shown
// once.
module point_in_polygon_test import ppt_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [IDX_W-1:0]              in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  output logic                          out_strobe,
  output logic                          out_inside_res,
  input  logic                          cfg_we,
  input  logic [CNT_W-1:0]              cfg_wdata
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int IXW = AW + IDX_W;
  localparam int NXW = CW + CNT_W;
  localparam int EW  = 2 * COORD_WIDTH;

  ppt_state_t state_r, state_nxt;

  logic [CNT_W-1:0]              vertex_count_r;
  logic [CW-1:0]                 n_r, n_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic signed [COORD_WIDTH-1:0] qx_r, qy_r;
  logic                          rd_vld_r, rd_first_r;
  logic                          out_strobe_r, out_strobe_nxt;
  logic                          out_inside_r;

  logic [EW-1:0]                 mem [MAX_VERTICES];
  logic [EW-1:0]                 rd_data_r;

  logic                          accept;
  logic                          wr_en;
  logic [IXW-1:0]                idx_wide;
  logic [AW-1:0]                 rd_addr;
  logic                          issue;
  logic                          clear;
  logic [NXW-1:0]                count_wide;
  logic [CW-1:0]                 n_clip;
  logic                          parity;
  logic                          pipe_busy;
  ppt_edge_ctl_t                 edge_ctl;

  assign accept   = start & ~busy;
  assign idx_wide = IXW'(in_vertex_index);
  assign wr_en    = accept && (in_cmd == CMD_STORE) &&
                    (idx_wide < IXW'(MAX_VERTICES));

  // Vertex count capped at store depth
  assign count_wide = NXW'(vertex_count_r);
  assign n_clip = (count_wide > NXW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                    : CW'(vertex_count_r);

  // Walk reads 0..n-1, then vertex 0 again to close the polygon
  assign rd_addr = (cnt_r == n_r) ? '0 : cnt_r[AW-1:0];

  // Vertex store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_wide[AW-1:0]] <= {in_coord_x, in_coord_y};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    issue          = 1'b0;
    clear          = 1'b0;
    out_strobe_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_QUERY) begin
          clear   = 1'b1;
          n_nxt   = n_clip;
          cnt_nxt = '0;
          state_nxt = (n_clip == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !pipe_busy) begin
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      vertex_count_r <= '0;
      rd_vld_r       <= 1'b0;
      out_strobe_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= issue;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        vertex_count_r <= cfg_wdata;
      end
    end
  end

  // Query payload and counters
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    cnt_r        <= cnt_nxt;
    rd_first_r   <= issue && (cnt_r == '0);
    out_inside_r <= parity;
    if (accept) begin
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
    end
  end

  assign edge_ctl.clear    = clear;
  assign edge_ctl.rd_vld   = rd_vld_r;
  assign edge_ctl.rd_first = rd_first_r;

  ppt_edge_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (edge_ctl),
    .rd_x      (rd_data_r[EW-1:COORD_WIDTH]),
    .rd_y      (rd_data_r[COORD_WIDTH-1:0]),
    .qx        (qx_r),
    .qy        (qy_r),
    .parity    (parity),
    .pipe_busy (pipe_busy)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_inside_res = out_inside_r;

endmodule
